// ----- rtl/macd_histogram_assert.svh -----
// assertion macros for the macd histogram block
// each use sits inside a module that has clk and arst_n
`ifndef MACD_HISTOGRAM_ASSERT_SVH
`define MACD_HISTOGRAM_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MACD_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("macd_histogram: assertion failed");
`define MACD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("macd_histogram: assertion failed");
`else
`define MACD_ASSERT(label, prop)
`define MACD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- rtl/macd_pkg.sv -----
package macd_pkg;

	localparam int PRICE_BITS = 32;
	localparam int GUARD_BITS = 16;
	localparam int AVG_BITS   = PRICE_BITS + GUARD_BITS;
	localparam int DIFF_BITS  = AVG_BITS + 1;
	localparam int ALPHA_BITS = 17;
	localparam int LO_BITS    = 24;
	localparam int HI_BITS    = DIFF_BITS - LO_BITS;
	localparam int PL_BITS    = LO_BITS + ALPHA_BITS;
	localparam int PH_BITS    = HI_BITS + ALPHA_BITS + 1;
	localparam int PROD_BITS  = PH_BITS + LO_BITS;
	localparam int HIST_BITS  = DIFF_BITS + 1;
	localparam int CFG_IDX_BITS = 2;

	localparam logic [ALPHA_BITS-1:0] ALPHA_ONE          = ALPHA_BITS'(65536);
	localparam logic [ALPHA_BITS-1:0] LONG_ALPHA_RESET   = ALPHA_BITS'(4855);
	localparam logic [ALPHA_BITS-1:0] SHORT_ALPHA_RESET  = ALPHA_BITS'(10082);
	localparam logic [ALPHA_BITS-1:0] SIGNAL_ALPHA_RESET = ALPHA_BITS'(13107);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_LONG_ALPHA   = 2'd0,
		CFG_SHORT_ALPHA  = 2'd1,
		CFG_SIGNAL_ALPHA = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic capture;
		logic diff;
		logic mul;
		logic sel_sig;
		logic upd_ls;
		logic macd;
		logic sdiff;
		logic upd_s;
		logic load_first;
		logic push_zero;
		logic push_hist;
	} dp_cmd_t;

	typedef struct packed {
		logic first;
	} dp_sts_t;

endpackage

// ----- rtl/macd_ctrl.sv -----
`include "macd_histogram_assert.svh"

module macd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output macd_pkg::dp_cmd_t cmd,
	input  macd_pkg::dp_sts_t sts
);
	import macd_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIFF,
		ST_LOAD,
		ST_MUL,
		ST_UPD,
		ST_MACD,
		ST_SDIFF,
		ST_MUL_S,
		ST_UPD_S,
		ST_HIST
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE:  cmd.capture = accept;
			ST_DIFF:  cmd.diff = 1'b1;
			ST_LOAD: begin
				cmd.load_first = out_free;
				cmd.push_zero  = out_free;
			end
			ST_MUL:   cmd.mul = 1'b1;
			ST_UPD:   cmd.upd_ls = 1'b1;
			ST_MACD:  cmd.macd = 1'b1;
			ST_SDIFF: cmd.sdiff = 1'b1;
			ST_MUL_S: begin
				cmd.mul     = 1'b1;
				cmd.sel_sig = 1'b1;
			end
			ST_UPD_S: begin
				cmd.sel_sig = 1'b1;
				cmd.upd_s   = 1'b1;
			end
			ST_HIST:  cmd.push_hist = out_free;
			default:  cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept)
						state_q <= ST_DIFF;
				end
				// the first flag is in the datapath register by now
				ST_DIFF:  state_q <= sts.first ? ST_LOAD : ST_MUL;
				ST_LOAD: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				ST_MUL:   state_q <= ST_UPD;
				ST_UPD:   state_q <= ST_MACD;
				ST_MACD:  state_q <= ST_SDIFF;
				ST_SDIFF: state_q <= ST_MUL_S;
				ST_MUL_S: state_q <= ST_UPD_S;
				ST_UPD_S: state_q <= ST_HIST;
				ST_HIST: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	`MACD_ASSERT_NEXT(a_accept_starts, accept, state_q == ST_DIFF)
	`MACD_ASSERT(a_word_from_push,
		$rose(out_valid_q) |-> $past(state_q == ST_HIST || state_q == ST_LOAD))
	`MACD_ASSERT_NEXT(a_hist_waits, state_q == ST_HIST && !out_free, state_q == ST_HIST)
	`MACD_ASSERT(a_one_update, $onehot0({cmd.upd_ls, cmd.upd_s, cmd.load_first}))

endmodule

// ----- rtl/macd_dpath.sv -----
`include "macd_histogram_assert.svh"

module macd_dpath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic signed [macd_pkg::PRICE_BITS-1:0] price,
	input  logic                                  first,
	output logic signed [macd_pkg::PRICE_BITS-1:0] histogram,
	input  logic                                  cfg_we,
	input  logic [macd_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [macd_pkg::ALPHA_BITS-1:0]       cfg_data,
	input  macd_pkg::dp_cmd_t                     cmd,
	output macd_pkg::dp_sts_t                     sts
);
	import macd_pkg::*;

	logic [ALPHA_BITS-1:0] long_alpha_q, short_alpha_q, signal_alpha_q;
	logic [ALPHA_BITS-1:0] cfg_eff;

	logic [PRICE_BITS-1:0] price_q;
	logic                  first_q;
	logic [AVG_BITS-1:0]   long_avg_q, short_avg_q, signal_avg_q;
	logic [DIFF_BITS-1:0]  da_q, db_q;
	logic [DIFF_BITS-1:0]  macd_q;
	logic [PRICE_BITS-1:0] hist_q;

	logic [PL_BITS-1:0]    pla_s1, plb_s1;
	logic [PH_BITS-1:0]    pha_s1, phb_s1;

	logic [AVG_BITS-1:0]   x;
	logic [ALPHA_BITS-1:0] alpha_a;
	logic [PROD_BITS-1:0]  prod_a, prod_b;
	logic [DIFF_BITS-1:0]  res_a, res_b;
	logic [AVG_BITS-1:0]   macd_sat;
	logic [HIST_BITS-1:0]  hdiff;
	logic [HIST_BITS-GUARD_BITS-1:0] hshift;
	logic [PRICE_BITS-1:0] hist_sat;

	// alpha above one is clamped once, at write time
	assign cfg_eff = (cfg_data > ALPHA_ONE) ? ALPHA_ONE : cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_alpha_q   <= LONG_ALPHA_RESET;
			short_alpha_q  <= SHORT_ALPHA_RESET;
			signal_alpha_q <= SIGNAL_ALPHA_RESET;
		end else if (cfg_we) begin
			if (cfg_index == CFG_LONG_ALPHA)
				long_alpha_q <= cfg_eff;
			if (cfg_index == CFG_SHORT_ALPHA)
				short_alpha_q <= cfg_eff;
			if (cfg_index == CFG_SIGNAL_ALPHA)
				signal_alpha_q <= cfg_eff;
		end
	end

	assign x       = {price_q, {GUARD_BITS{1'b0}}};
	assign alpha_a = cmd.sel_sig ? signal_alpha_q : long_alpha_q;

	// product of the split partial products, floor by dropping the low bits
	assign prod_a = {pha_s1, {LO_BITS{1'b0}}} + {{(PROD_BITS-PL_BITS){1'b0}}, pla_s1};
	assign prod_b = {phb_s1, {LO_BITS{1'b0}}} + {{(PROD_BITS-PL_BITS){1'b0}}, plb_s1};
	assign res_a  = prod_a[DIFF_BITS+GUARD_BITS-1:GUARD_BITS];
	assign res_b  = prod_b[DIFF_BITS+GUARD_BITS-1:GUARD_BITS];

	// macd clamped to the state range before it feeds the signal average
	assign macd_sat = (macd_q[DIFF_BITS-1] != macd_q[DIFF_BITS-2]) ?
		{macd_q[DIFF_BITS-1], {(AVG_BITS-1){~macd_q[DIFF_BITS-1]}}} :
		macd_q[AVG_BITS-1:0];

	assign hdiff  = {macd_q[DIFF_BITS-1], macd_q} -
		{{2{signal_avg_q[AVG_BITS-1]}}, signal_avg_q};
	assign hshift = hdiff[HIST_BITS-1:GUARD_BITS];
	assign hist_sat = (hshift[HIST_BITS-GUARD_BITS-1:PRICE_BITS-1] == '0 ||
		hshift[HIST_BITS-GUARD_BITS-1:PRICE_BITS-1] == '1) ?
		hshift[PRICE_BITS-1:0] :
		{hshift[HIST_BITS-GUARD_BITS-1], {(PRICE_BITS-1){~hshift[HIST_BITS-GUARD_BITS-1]}}};

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			price_q <= price;
			first_q <= first;
		end
		if (cmd.diff) begin
			da_q <= {x[AVG_BITS-1], x} - {long_avg_q[AVG_BITS-1], long_avg_q};
			db_q <= {x[AVG_BITS-1], x} - {short_avg_q[AVG_BITS-1], short_avg_q};
		end else if (cmd.sdiff) begin
			da_q <= {macd_sat[AVG_BITS-1], macd_sat} -
				{signal_avg_q[AVG_BITS-1], signal_avg_q};
		end
		if (cmd.mul) begin
			pla_s1 <= {{ALPHA_BITS{1'b0}}, da_q[LO_BITS-1:0]} * {{LO_BITS{1'b0}}, alpha_a};
			plb_s1 <= {{ALPHA_BITS{1'b0}}, db_q[LO_BITS-1:0]} *
				{{LO_BITS{1'b0}}, short_alpha_q};
			pha_s1 <= $signed({{(ALPHA_BITS+1){da_q[DIFF_BITS-1]}}, da_q[DIFF_BITS-1:LO_BITS]}) *
				$signed({{HI_BITS{1'b0}}, 1'b0, alpha_a});
			phb_s1 <= $signed({{(ALPHA_BITS+1){db_q[DIFF_BITS-1]}}, db_q[DIFF_BITS-1:LO_BITS]}) *
				$signed({{HI_BITS{1'b0}}, 1'b0, short_alpha_q});
		end
		if (cmd.macd)
			macd_q <= {short_avg_q[AVG_BITS-1], short_avg_q} -
				{long_avg_q[AVG_BITS-1], long_avg_q};
		if (cmd.push_zero)
			hist_q <= '0;
		else if (cmd.push_hist)
			hist_q <= hist_sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_avg_q   <= '0;
			short_avg_q  <= '0;
			signal_avg_q <= '0;
		end else if (cmd.load_first) begin
			long_avg_q   <= x;
			short_avg_q  <= x;
			signal_avg_q <= '0;
		end else if (cmd.upd_ls) begin
			long_avg_q  <= long_avg_q + res_a[AVG_BITS-1:0];
			short_avg_q <= short_avg_q + res_b[AVG_BITS-1:0];
		end else if (cmd.upd_s) begin
			signal_avg_q <= signal_avg_q + res_a[AVG_BITS-1:0];
		end
	end

	assign histogram = hist_q;
	assign sts.first = first_q;

	`MACD_ASSERT_NEXT(a_first_loads, cmd.load_first,
		long_avg_q == short_avg_q && signal_avg_q == '0)
	`MACD_ASSERT_NEXT(a_first_word_zero, cmd.push_zero, hist_q == '0)

endmodule

// ----- rtl/macd_histogram.sv -----
// macd histogram: one signed q16.16 closing price per input word, one
// signed q16.16 histogram word out per input word, (short - long) - signal
// with all three averages kept in 48-bit extended format.
// input channel: in_valid / in_stall with price and first; first restarts
// the averages and its output word is zero.
// output channel: out_valid / out_stall with histogram, held in an output
// register that stays stable while out_stall is high.
// config: cfg_we writes cfg_data into register cfg_index (0 long alpha,
// 1 short alpha, 2 signal alpha, q1.16); index 3 is ignored. write only
// while the block is idle.
// the sequencer steps diff, multiply, update for the two price averages,
// then macd, diff, multiply, update on the shared multiplier for the
// signal average, then the saturating output step; for a first word the
// diff step is followed instead by a step that loads the averages and
// pushes zero. no new word is taken until the sequencer is back in idle.
// a stalled output register holds the sequencer in its last step, and
// in_stall stays high until the word is in the output register.
// reset clears the averages to zero and restores the default alphas.
module macd_histogram (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [macd_pkg::PRICE_BITS-1:0] price,
	input  logic                                   first,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [macd_pkg::PRICE_BITS-1:0] histogram,
	input  logic                                   cfg_we,
	input  logic [macd_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [macd_pkg::ALPHA_BITS-1:0]        cfg_data
);
	import macd_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	macd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	macd_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.price     (price),
		.first     (first),
		.histogram (histogram),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// ----- tb/tb_macd_histogram.sv -----
`timescale 1ns / 1ps

module tb_macd_histogram;
	import macd_pkg::*;

	typedef logic signed [PRICE_BITS-1:0] price_t;
	typedef logic signed [AVG_BITS-1:0]   avg_t;
	typedef logic signed [DIFF_BITS-1:0]  diff_t;
	typedef logic        [ALPHA_BITS-1:0] alpha_t;

	typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t                 kind;
		logic [CFG_IDX_BITS-1:0]   idx;
		alpha_t                    val;
		price_t                    px;
		logic                      fst;
		logic                      chk;
		price_t                    hist;
	} row_t;

	localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;
	localparam alpha_t ALPHA_TOP = '1;
	localparam price_t P_MAX = {1'b0, {(PRICE_BITS-1){1'b1}}};
	localparam price_t P_MIN = {1'b1, {(PRICE_BITS-1){1'b0}}};
	localparam avg_t   EXT_MAX = {1'b0, {(AVG_BITS-1){1'b1}}};
	localparam avg_t   EXT_MIN = {1'b1, {(AVG_BITS-1){1'b0}}};
	localparam int     IDLE_PAUSE = 12;
	localparam int     END_SETTLE = 24;
	localparam int     STALL_LIMIT = 2000;
	localparam int     PHASES = 7;
	localparam int     WORDS_PER_PHASE = 100;
	localparam int     PLAN_LEN = 31;

	localparam row_t PLAN [0:PLAN_LEN-1] = '{
		// no series start yet, averages move from zero
		'{ROW_WORD, '0, '0, 32'sh0001_0000, 1'b0, 1'b0, '0},
		'{ROW_WORD, '0, '0, P_MAX,          1'b0, 1'b0, '0},
		'{ROW_WORD, '0, '0, P_MIN,          1'b0, 1'b0, '0},
		'{ROW_WORD, '0, '0, 32'sh0064_8000, 1'b1, 1'b1, '0},
		'{ROW_WORD, '0, '0, 32'sh0065_0000, 1'b0, 1'b0, '0},
		'{ROW_WORD, '0, '0, 32'sh0063_0000, 1'b0, 1'b0, '0},
		'{ROW_WORD, '0, '0, P_MIN,          1'b1, 1'b1, '0},
		'{ROW_WORD, '0, '0, P_MAX,          1'b0, 1'b0, '0},
		// long frozen, short tracks exactly, signal frozen
		'{ROW_CFG, CFG_LONG_ALPHA,   '0,        '0, 1'b0, 1'b0, '0},
		'{ROW_CFG, CFG_SHORT_ALPHA,  ALPHA_ONE, '0, 1'b0, 1'b0, '0},
		'{ROW_CFG, CFG_SIGNAL_ALPHA, '0,        '0, 1'b0, 1'b0, '0},
		'{ROW_CFG, CFG_SPARE,        ALPHA_TOP, '0, 1'b0, 1'b0, '0},
		'{ROW_WORD, '0, '0, P_MIN,          1'b1, 1'b1, '0},
		'{ROW_WORD, '0, '0, P_MAX,          1'b0, 1'b1, P_MAX},
		'{ROW_WORD, '0, '0, P_MAX,          1'b1, 1'b1, '0},
		'{ROW_WORD, '0, '0, P_MIN,          1'b0, 1'b1, P_MIN},
		// signal alpha above one acts as one
		'{ROW_CFG, CFG_LONG_ALPHA,   ALPHA_ONE, '0, 1'b0, 1'b0, '0},
		'{ROW_CFG, CFG_SHORT_ALPHA,  '0,        '0, 1'b0, 1'b0, '0},
		'{ROW_CFG, CFG_SIGNAL_ALPHA, ALPHA_TOP, '0, 1'b0, 1'b0, '0},
		'{ROW_WORD, '0, '0, '0,             1'b1, 1'b1, '0},
		'{ROW_WORD, '0, '0, P_MAX,          1'b0, 1'b1, '0},
		'{ROW_WORD, '0, '0, 32'shFFFF_FFFF, 1'b0, 1'b0, '0},
		// macd overflows the signal input, which clips one lsb short
		'{ROW_WORD, '0, '0, P_MIN,          1'b0, 1'b1, '0},
		'{ROW_WORD, '0, '0, 32'sh5555_5555, 1'b0, 1'b0, '0},
		'{ROW_WORD, '0, '0, 32'shAAAA_AAAA, 1'b0, 1'b0, '0},
		'{ROW_CFG, CFG_LONG_ALPHA,   17'd1,     '0, 1'b0, 1'b0, '0},
		'{ROW_CFG, CFG_SHORT_ALPHA,  17'd1,     '0, 1'b0, 1'b0, '0},
		'{ROW_CFG, CFG_SIGNAL_ALPHA, 17'd1,     '0, 1'b0, 1'b0, '0},
		'{ROW_WORD, '0, '0, 32'sh1234_5678, 1'b1, 1'b1, '0},
		'{ROW_WORD, '0, '0, 32'shEDCB_A988, 1'b0, 1'b0, '0},
		'{ROW_WORD, '0, '0, P_MAX,          1'b0, 1'b0, '0}
	};

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_stall;
	price_t                  price;
	logic                    first;
	logic                    out_valid;
	logic                    out_stall;
	price_t                  histogram;
	logic                    cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	alpha_t                  cfg_data;

	// shadow of the block state
	alpha_t long_alpha_sh;
	alpha_t short_alpha_sh;
	alpha_t signal_alpha_sh;
	avg_t   long_ema;
	avg_t   short_ema;
	avg_t   signal_ema;

	price_t pending_hist[$];
	int     mismatches;
	int     idle_cycles;
	bit     send_calm;
	bit     recv_calm;

	macd_histogram i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.price     (price),
		.first     (first),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.histogram (histogram),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// floor(d * alpha / 2^16), alpha clipped to one
	function automatic diff_t scaled_step(diff_t d, alpha_t a);
		alpha_t                                   ae;
		logic signed [DIFF_BITS+ALPHA_BITS:0] p;
		ae = (a > ALPHA_ONE) ? ALPHA_ONE : a;
		p = d * $signed({1'b0, ae});
		return p[DIFF_BITS+15:16];
	endfunction

	function automatic avg_t ema_next(avg_t avg, avg_t x, alpha_t a);
		diff_t d;
		diff_t s;
		d = x - avg;
		s = avg + scaled_step(d, a);
		return s[AVG_BITS-1:0];
	endfunction

	function automatic price_t advance_histogram(price_t px, logic fst);
		avg_t                              x;
		diff_t                             macd;
		avg_t                              macd_clip;
		logic signed [DIFF_BITS:0]         gap;
		logic signed [DIFF_BITS-GUARD_BITS:0] coarse;
		x = {px, {GUARD_BITS{1'b0}}};
		if (fst) begin
			long_ema = x;
			short_ema = x;
			signal_ema = '0;
			return '0;
		end
		long_ema = ema_next(long_ema, x, long_alpha_sh);
		short_ema = ema_next(short_ema, x, short_alpha_sh);
		macd = short_ema - long_ema;
		if (macd > EXT_MAX)
			macd_clip = EXT_MAX;
		else if (macd < EXT_MIN)
			macd_clip = EXT_MIN;
		else
			macd_clip = macd[AVG_BITS-1:0];
		signal_ema = ema_next(signal_ema, macd_clip, signal_alpha_sh);
		gap = macd - signal_ema;
		coarse = gap >>> GUARD_BITS;
		if (coarse > P_MAX)
			return P_MAX;
		if (coarse < P_MIN)
			return P_MIN;
		return coarse[PRICE_BITS-1:0];
	endfunction

	function automatic int draw_wait(inout bit calm);
		if ($urandom_range(0, 39) == 0)
			calm = !calm;
		return calm ? 0 : $urandom_range(0, 16);
	endfunction

	function automatic alpha_t pick_alpha();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return 17'd1;
			2: return ALPHA_ONE;
			3: return alpha_t'($urandom_range(65537, 131071));
			4: return alpha_t'($urandom_range(1, 65536));
			default: return alpha_t'($urandom_range(500, 30000));
		endcase
	endfunction

	task automatic flag(input string what);
		mismatches++;
		$display("ERROR %0t: %s", $time, what);
	endtask

	task automatic send_word(input price_t px, input logic fst, input bit typed,
		input price_t want);
		price_t guess;
		int     gap;
		in_valid <= 1'b1;
		price <= px;
		first <= fst;
		do @(posedge clk); while (in_stall);
		guess = advance_histogram(px, fst);
		pending_hist = {pending_hist, (typed ? want : guess)};
		gap = draw_wait(send_calm);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_results(input int settle);
		if (in_valid)
			in_valid <= 1'b0;
		while (pending_hist.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// leaves cfg_we high so that writes can follow back to back
	task automatic write_alpha(input logic [CFG_IDX_BITS-1:0] idx, input alpha_t val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			CFG_LONG_ALPHA:   long_alpha_sh = val;
			CFG_SHORT_ALPHA:  short_alpha_sh = val;
			CFG_SIGNAL_ALPHA: signal_alpha_sh = val;
			default: ;
		endcase
	endtask

	initial begin
		int     ph;
		int     sent;
		int     len;
		int     shift;
		bit     cfg_open;
		price_t px;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		price <= '0;
		first <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_LONG_ALPHA;
		cfg_data <= '0;
		long_alpha_sh = LONG_ALPHA_RESET;
		short_alpha_sh = SHORT_ALPHA_RESET;
		signal_alpha_sh = SIGNAL_ALPHA_RESET;
		long_ema = '0;
		short_ema = '0;
		signal_ema = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		cfg_open = 1'b0;
		for (int r = 0; r < PLAN_LEN; r++) begin
			if (PLAN[r].kind == ROW_CFG) begin
				if (!cfg_open) begin
					drain_results(IDLE_PAUSE);
					cfg_open = 1'b1;
				end
				write_alpha(PLAN[r].idx, PLAN[r].val);
			end else begin
				if (cfg_open) begin
					cfg_we <= 1'b0;
					cfg_open = 1'b0;
				end
				send_word(PLAN[r].px, PLAN[r].fst, PLAN[r].chk, PLAN[r].hist);
			end
		end

		for (ph = 0; ph < PHASES; ph++) begin
			drain_results(IDLE_PAUSE);
			write_alpha(CFG_LONG_ALPHA, pick_alpha());
			write_alpha(CFG_SHORT_ALPHA, pick_alpha());
			write_alpha(CFG_SIGNAL_ALPHA, pick_alpha());
			if ($urandom_range(0, 2) == 0)
				write_alpha(CFG_SPARE, alpha_t'($urandom));
			cfg_we <= 1'b0;
			sent = 0;
			while (sent < WORDS_PER_PHASE) begin
				if ($urandom_range(0, 9) == 0) begin
					// stray word, often continuing a series without a start
					send_word(price_t'($urandom), 1'($urandom_range(0, 1)), 1'b0, '0);
					sent++;
				end else begin
					len = $urandom_range(1, 40);
					shift = $urandom_range(0, 28);
					px = price_t'($urandom);
					send_word(px, 1'b1, 1'b0, '0);
					for (int k = 0; k < len; k++) begin
						px = px + ($signed($urandom) >>> shift);
						send_word(px, 1'b0, 1'b0, '0);
					end
					sent += len + 1;
				end
				if ($urandom_range(0, 29) == 0)
					drain_results(0);
			end
		end

		drain_results(END_SETTLE);
		if (pending_hist.size() != 0)
			flag($sformatf("%0d histogram words never arrived", pending_hist.size()));
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		int n;
		out_stall <= 1'b0;
		forever begin
			n = draw_wait(recv_calm);
			if (n != 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (out_valid !== 1'b1);
		end
	end

	always @(posedge clk) begin
		price_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_hist.size() == 0) begin
					flag($sformatf("histogram word %0d with nothing expected", histogram));
				end else begin
					want = pending_hist.pop_front();
					if (histogram !== want)
						flag($sformatf("histogram %0d, expected %0d", histogram, want));
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end else begin
			idle_cycles <= 0;
		end
	end

endmodule

// ----- macd_histogram.f -----
+incdir+rtl
rtl/macd_pkg.sv
rtl/macd_ctrl.sv
rtl/macd_dpath.sv
rtl/macd_histogram.sv
tb/tb_macd_histogram.sv
